// File: src/vsync_phase_lock_unit_macros.svh
// ---------------------------------------------------------------------------
// vsync phase lock unit assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef VSYNC_PHASE_LOCK_UNIT_MACROS_SVH
`define VSYNC_PHASE_LOCK_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define VSPL_ASSERT_CLK(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);
`define VSPL_ASSERT(lbl, prop, msg) `VSPL_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`else
`define VSPL_ASSERT_CLK(lbl, clk_s, rstn_s, prop, msg)
`define VSPL_ASSERT(lbl, prop, msg)
`endif
`endif

// File: src/vspl_pkg.sv
// ---------------------------------------------------------------------------
// vsync phase lock package
// Status codes, request codes, register indexes and fixed widths.
// ---------------------------------------------------------------------------
package vspl_pkg;

  localparam int TP_BITS      = 9;
  localparam int CORR_BITS    = 7;
  localparam int REQ_BITS     = 2;
  localparam int STATUS_BITS  = 3;
  localparam int CFG_IDX_BITS = 3;
  localparam int MCNT_BITS    = $clog2(TP_BITS + 1);

  localparam logic [TP_BITS-1:0]   DEG_FULL     = 9'd360;
  localparam logic [1:0]           SETTLE_ITEMS = 2'd2;
  localparam logic [TP_BITS-1:0]   TP_RESET     = 9'd180;
  localparam logic [CORR_BITS-1:0] STEP_RESET   = 7'd2;

  localparam logic [REQ_BITS-1:0] REQ_MEASURE = 2'd0;
  localparam logic [REQ_BITS-1:0] REQ_RESET   = 2'd1;
  localparam logic [REQ_BITS-1:0] REQ_ARM     = 2'd2;
  localparam logic [REQ_BITS-1:0] REQ_UNUSED  = 2'd3;

  localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET_PHASE = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CORR_STEP    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOCK_METHOD  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BASE_VTOTAL  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BASE_VSYNC   = 3'd4;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_NOT_READY  = 3'd0,
    ST_SETTLING   = 3'd1,
    ST_FAILED     = 3'd2,
    ST_UNCHANGED  = 3'd3,
    ST_ADJUSTED   = 3'd4,
    ST_RESET_DONE = 3'd5,
    ST_ARMED      = 3'd6
  } status_t;

endpackage

// File: src/vsync_phase_lock_unit.sv
// ---------------------------------------------------------------------------
// vsync phase lock unit
// Measures input period and output phase from vsync timestamps and trims
// the output frame length to hold the output at a target phase.
// ---------------------------------------------------------------------------
//  channel   handshake              payload
//  in        in_valid / in_ready    in_req_type, in_in_start, in_in_stop,
//                                   in_out_start, in_out_stop
//  out       out_valid / out_ready  out_status, out_write_timing, out_vtotal,
//                                   out_vsync_start, out_period,
//                                   out_phase_cycles, out_target_cycles
//  cfg       cfg_we                 cfg_index, cfg_wdata
//
// a full measurement runs a shift-add multiply, then a STAMP_BITS + 9 step
// serial divide by 360, while the phase modulo runs in a second serial divider
// alongside; every other request goes straight to the commit state
// one request is in work at a time
// the result register lets the next request in while a result waits
// reset (rst_n low, synchronous) clears lock state and loads register defaults
// ---------------------------------------------------------------------------
`include "vsync_phase_lock_unit_macros.svh"

module vsync_phase_lock_unit #(
  parameter int STAMP_BITS = 32,
  parameter int LINE_BITS  = 11
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_we,
  input  logic [vspl_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [((LINE_BITS > vspl_pkg::TP_BITS) ? LINE_BITS : vspl_pkg::TP_BITS)-1:0]
                                               cfg_wdata,
  // requests
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [vspl_pkg::REQ_BITS-1:0]        in_req_type,
  input  logic [STAMP_BITS-1:0]                in_in_start,
  input  logic [STAMP_BITS-1:0]                in_in_stop,
  input  logic [STAMP_BITS-1:0]                in_out_start,
  input  logic [STAMP_BITS-1:0]                in_out_stop,
  // results
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [vspl_pkg::STATUS_BITS-1:0]     out_status,
  output logic                                 out_write_timing,
  output logic [LINE_BITS-1:0]                 out_vtotal,
  output logic [LINE_BITS-1:0]                 out_vsync_start,
  output logic [STAMP_BITS-1:0]                out_period,
  output logic [STAMP_BITS-1:0]                out_phase_cycles,
  output logic [STAMP_BITS-1:0]                out_target_cycles
);

  import vspl_pkg::*;

  localparam int PW = STAMP_BITS + TP_BITS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_TDIV,
    S_DONE
  } state_t;

  state_t                state_r;

  // configuration registers
  logic [TP_BITS-1:0]    tp_r;
  logic [CORR_BITS-1:0]  step_r;
  logic                  method_r;
  logic [LINE_BITS-1:0]  base_vt_r;
  logic [LINE_BITS-1:0]  base_vs_r;

  // lock state
  logic                  lock_ready_r;
  logic [1:0]            settle_r;
  logic [CORR_BITS-1:0]  applied_r;

  // work registers
  status_t               pend_r;
  logic [STAMP_BITS-1:0] period_r;
  logic [TP_BITS-1:0]    tp_sh_r;
  logic [PW-1:0]         prod_r;
  logic [MCNT_BITS-1:0]  mcnt_r;

  // result register
  logic                  out_valid_r;
  status_t               out_status_r;
  logic                  out_wt_r;
  logic [LINE_BITS-1:0]  out_vt_r;
  logic [LINE_BITS-1:0]  out_vs_r;
  logic [STAMP_BITS-1:0] out_period_r;
  logic [STAMP_BITS-1:0] out_phase_r;
  logic [STAMP_BITS-1:0] out_target_r;

  // accept side
  logic                  stamps_bad;
  status_t               acc_status;
  logic                  acc_calc;
  logic [STAMP_BITS-1:0] acc_period;
  logic [STAMP_BITS-1:0] acc_offset;

  // serial units
  logic                  mod_start;
  logic                  mod_busy;
  logic [STAMP_BITS-1:0] mod_quo;
  logic [STAMP_BITS-1:0] mod_rem;
  logic                  tdiv_start;
  logic                  tdiv_busy;
  logic [PW-1:0]         tdiv_quo;
  logic [TP_BITS-1:0]    tdiv_rem;
  logic [PW-1:0]         prod_nxt;

  // commit side
  logic [STAMP_BITS-1:0] target;
  logic [CORR_BITS-1:0]  corr_meas;
  logic [CORR_BITS-1:0]  corr_eff;
  logic [LINE_BITS-1:0]  corr_ext;
  status_t               cmt_status;
  logic                  cmt_wt;
  logic                  cmt_meas;
  logic                  commit;

  always_comb begin
    acc_period = in_in_stop - in_in_start;
    acc_offset = in_out_start - in_in_start;
    stamps_bad = (in_in_start == '0) || (in_in_stop == '0) ||
                 (in_out_start == '0) || (in_out_stop == '0) ||
                 (in_in_start >= in_in_stop) || (in_out_start >= in_out_stop);
    if (in_req_type == REQ_RESET) begin
      acc_status = ST_RESET_DONE;
    end else if (in_req_type == REQ_ARM) begin
      acc_status = ST_ARMED;
    end else if (in_req_type == REQ_UNUSED || !lock_ready_r) begin
      acc_status = ST_NOT_READY;
    end else if (settle_r < SETTLE_ITEMS) begin
      acc_status = ST_SETTLING;
    end else if (stamps_bad) begin
      acc_status = ST_FAILED;
    end else begin
      // full measurement; final status chosen at commit
      acc_status = ST_UNCHANGED;
    end
    acc_calc = acc_status == ST_UNCHANGED;
  end

  assign in_ready   = state_r == S_IDLE;
  assign mod_start  = in_valid && in_ready && acc_calc;
  assign tdiv_start = (state_r == S_MUL) && (mcnt_r == '0);
  assign prod_nxt   = {prod_r[PW-2:0], 1'b0} +
                      (tp_sh_r[TP_BITS-1] ? {{TP_BITS{1'b0}}, period_r} : '0);

  vspl_div #(
    .N (STAMP_BITS),
    .M (STAMP_BITS)
  ) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (acc_offset),
    .divisor   (acc_period),
    .busy      (mod_busy),
    .quotient  (mod_quo),
    .remainder (mod_rem)
  );

  vspl_div #(
    .N (PW),
    .M (TP_BITS)
  ) u_tdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (tdiv_start),
    .dividend  (prod_r),
    .divisor   (DEG_FULL),
    .busy      (tdiv_busy),
    .quotient  (tdiv_quo),
    .remainder (tdiv_rem)
  );

  always_comb begin
    // quotient above the stamp range saturates
    target    = (|tdiv_quo[PW-1:STAMP_BITS]) ? '1 : tdiv_quo[STAMP_BITS-1:0];
    corr_meas = (mod_rem > target) ? '0 : step_r;
    cmt_meas  = pend_r == ST_UNCHANGED;
    case (pend_r)
      ST_RESET_DONE: corr_eff = '0;
      ST_UNCHANGED:  corr_eff = corr_meas;
      default:       corr_eff = applied_r;
    endcase
    corr_ext = {{(LINE_BITS - CORR_BITS){corr_eff[CORR_BITS-1]}}, corr_eff};
    if (cmt_meas) begin
      cmt_status = (corr_meas == applied_r) ? ST_UNCHANGED : ST_ADJUSTED;
      cmt_wt     = corr_meas != applied_r;
    end else begin
      cmt_status = pend_r;
      cmt_wt     = (pend_r == ST_RESET_DONE) && (applied_r != '0);
    end
    commit = (state_r == S_DONE) && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      lock_ready_r <= 1'b0;
      settle_r     <= '0;
      applied_r    <= '0;
      tp_r         <= TP_RESET;
      step_r       <= STEP_RESET;
      method_r     <= 1'b0;
      base_vt_r    <= '0;
      base_vs_r    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TARGET_PHASE: tp_r      <= cfg_wdata[TP_BITS-1:0];
          CFG_CORR_STEP:    step_r    <= cfg_wdata[CORR_BITS-1:0];
          CFG_LOCK_METHOD:  method_r  <= cfg_wdata[0];
          CFG_BASE_VTOTAL:  base_vt_r <= cfg_wdata[LINE_BITS-1:0];
          CFG_BASE_VSYNC:   base_vs_r <= cfg_wdata[LINE_BITS-1:0];
          default: ;
        endcase
      end

      // a commit in the same cycle reloads the result register instead
      if (out_valid_r && out_ready && !commit) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            pend_r <= acc_status;
            if (acc_calc) begin
              period_r <= acc_period;
              tp_sh_r  <= tp_r;
              prod_r   <= '0;
              mcnt_r   <= MCNT_BITS'(TP_BITS);
              state_r  <= S_MUL;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_MUL: begin
          if (mcnt_r != '0) begin
            prod_r  <= prod_nxt;
            tp_sh_r <= {tp_sh_r[TP_BITS-2:0], 1'b0};
            mcnt_r  <= mcnt_r - 1'b1;
          end else begin
            state_r <= S_TDIV;
          end
        end
        S_TDIV: begin
          if (!mod_busy && !tdiv_busy) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (commit) begin
            out_valid_r  <= 1'b1;
            out_status_r <= cmt_status;
            out_wt_r     <= cmt_wt;
            out_vt_r     <= base_vt_r + corr_ext;
            out_vs_r     <= method_r ? base_vs_r : base_vs_r + corr_ext;
            out_period_r <= cmt_meas ? period_r : '0;
            out_phase_r  <= cmt_meas ? mod_rem : '0;
            out_target_r <= cmt_meas ? target : '0;
            state_r      <= S_IDLE;
            case (pend_r)
              ST_RESET_DONE: begin
                lock_ready_r <= 1'b0;
                settle_r     <= '0;
                applied_r    <= '0;
              end
              ST_ARMED: begin
                lock_ready_r <= 1'b1;
                settle_r     <= '0;
              end
              ST_SETTLING:  settle_r  <= settle_r + 1'b1;
              ST_UNCHANGED: applied_r <= corr_meas;
              default: ;
            endcase
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_write_timing  = out_wt_r;
  assign out_vtotal        = out_vt_r;
  assign out_vsync_start   = out_vs_r;
  assign out_period        = out_period_r;
  assign out_phase_cycles  = out_phase_r;
  assign out_target_cycles = out_target_r;

  `VSPL_ASSERT(a_settle_needs_lock, !lock_ready_r |-> settle_r == '0,
               "settle count while unlocked")
  `VSPL_ASSERT(a_accept_leaves_idle, in_valid && in_ready |=> state_r != S_IDLE,
               "request lost")
  `VSPL_ASSERT(a_done_units_idle, state_r == S_DONE |-> !mod_busy && !tdiv_busy,
               "commit while busy")
  `VSPL_ASSERT(a_meas_period_nonzero,
               out_valid_r && (out_status_r == ST_UNCHANGED ||
               out_status_r == ST_ADJUSTED) |-> out_period_r != '0,
               "zero period measured")

endmodule

// File: src/vspl_div.sv
// ---------------------------------------------------------------------------
// vsync phase lock serial divider
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module vspl_div #(
  parameter int N = 32,
  parameter int M = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [M-1:0] divisor,
  output logic         busy,
  output logic [N-1:0] quotient,
  output logic [M-1:0] remainder
);

  localparam int CW = $clog2(N + 1);

  logic [N-1:0]  quo_r;
  logic [M-1:0]  rem_r;
  logic [M-1:0]  div_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;

  logic [M:0]    trial;
  logic [M:0]    diff;
  logic          ge;
  logic [M-1:0]  rem_nxt;

  always_comb begin
    // dividend bits shift out of the top while quotient bits shift in below
    trial   = {rem_r, quo_r[N-1]};
    diff    = trial - {1'b0, div_r};
    ge      = trial >= {1'b0, div_r};
    rem_nxt = ge ? diff[M-1:0] : trial[M-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(N);
      quo_r  <= dividend;
      rem_r  <= '0;
      div_r  <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[N-2:0], ge};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy      = busy_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
